FILE: src/vmn_pkg.sv
// shared types and constants for the vector magnitude and norm block
// no dependencies

package vmn_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int RAD_WIDTH    = 2 * SAMPLE_WIDTH;
   localparam int ROOT_WIDTH   = RAD_WIDTH / 2;
   localparam int REM_WIDTH    = ROOT_WIDTH + 1;
   localparam int RATIO_WIDTH  = 16;
   localparam int SQRT_STEPS   = ROOT_WIDTH;
   localparam int DIV_STEPS    = RATIO_WIDTH;
   localparam int SQ_STEPS     = 4;
   // one counter serves every phase, so it spans the longest one
   localparam int STEP_WIDTH   = $clog2((SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS);

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] accel_x;
      logic signed [SAMPLE_WIDTH-1:0] accel_y;
      logic signed [SAMPLE_WIDTH-1:0] accel_z;
   } vmn_req_type;

   typedef struct packed {
      logic        [ROOT_WIDTH-1:0]  vector_length;
      logic signed [RATIO_WIDTH-1:0] x_ratio;
   } vmn_rsp_type;

   // operand select of the shared squaring multiplier
   typedef enum logic [1:0] {
      SEL_X    = 2'd0,
      SEL_Y    = 2'd1,
      SEL_Z    = 2'd2,
      SEL_NONE = 2'd3
   } vmn_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        sq_step;
      vmn_sel_type sq_sel;
      logic        sqrt_step;
      logic        div_step;
      logic        load_out;
   } vmn_cmd_type;

endpackage

FILE: src/vmn_datapath.sv
// datapath: abs, shared squarer, bit-serial square root and divider, result register
// depends on vmn_pkg

module vmn_datapath
   import vmn_pkg::*;
(
   input  logic        clock,
   input  vmn_cmd_type cmd,
   input  vmn_req_type req_data,
   output vmn_rsp_type rsp_data
);

   function automatic logic [SAMPLE_WIDTH-1:0] abs_val(input logic [SAMPLE_WIDTH-1:0] v);
      logic [SAMPLE_WIDTH-1:0] r;
      r = v[SAMPLE_WIDTH-1] ? (~v + SAMPLE_WIDTH'(1)) : v;
      return r;
   endfunction

   logic [SAMPLE_WIDTH-1:0] ax_ff, ay_ff, az_ff;
   logic                    neg_ff;
   logic [RAD_WIDTH-1:0]    prod_ff;
   logic [RAD_WIDTH-1:0]    acc_ff;
   logic [REM_WIDTH-1:0]    srem_ff;
   logic [ROOT_WIDTH-1:0]   root_ff;
   logic [ROOT_WIDTH-1:0]   drem_ff;
   logic [RATIO_WIDTH-1:0]  ddvd_ff;
   logic [RATIO_WIDTH-1:0]  quo_ff;
   vmn_rsp_type             rsp_ff;

   logic [SAMPLE_WIDTH-1:0] ax_in;
   logic [SAMPLE_WIDTH-1:0] mul_op;
   logic [RAD_WIDTH-1:0]    mul_out;
   logic [REM_WIDTH+1:0]    srem_sh;
   logic [REM_WIDTH+1:0]    trial;
   logic [REM_WIDTH-1:0]    srem_in;
   logic [ROOT_WIDTH-1:0]   root_in;
   logic [ROOT_WIDTH:0]     drem_sh;
   logic [ROOT_WIDTH-1:0]   drem_in;
   logic                    qbit;
   logic [RATIO_WIDTH-1:0]  ratio;
   vmn_rsp_type             rsp_in;

   assign ax_in = abs_val(req_data.accel_x);

   // one squarer shared by the three axes
   always_comb begin
      unique case (cmd.sq_sel)
         SEL_X:    mul_op = ax_ff;
         SEL_Y:    mul_op = ay_ff;
         SEL_Z:    mul_op = az_ff;
         SEL_NONE: mul_op = '0;
         default:  mul_op = '0;
      endcase
   end

   assign mul_out = RAD_WIDTH'(mul_op) * RAD_WIDTH'(mul_op);

   // restoring square root, two radicand bits per step
   always_comb begin
      srem_sh = {srem_ff, acc_ff[RAD_WIDTH-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (srem_sh >= trial) begin
         srem_in = REM_WIDTH'(srem_sh - trial);
         root_in = {root_ff[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         srem_in = srem_sh[REM_WIDTH-1:0];
         root_in = {root_ff[ROOT_WIDTH-2:0], 1'b0};
      end
   end

   // restoring divide of |x| * 2^15 by the root, one quotient bit per step
   always_comb begin
      drem_sh = {drem_ff, ddvd_ff[RATIO_WIDTH-1]};
      qbit    = (drem_sh >= {1'b0, root_ff});
      if (qbit) begin
         drem_in = ROOT_WIDTH'(drem_sh - {1'b0, root_ff});
      end else begin
         drem_in = drem_sh[ROOT_WIDTH-1:0];
      end
   end

   // sign, saturation at plus one, zero length
   always_comb begin
      if (root_ff == '0) begin
         ratio = '0;
      end else if (neg_ff) begin
         ratio = ~quo_ff + RATIO_WIDTH'(1);
      end else if (quo_ff[RATIO_WIDTH-1]) begin
         ratio = {1'b0, {(RATIO_WIDTH-1){1'b1}}};
      end else begin
         ratio = quo_ff;
      end
      rsp_in.vector_length = root_ff;
      rsp_in.x_ratio       = ratio;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         ax_ff   <= ax_in;
         ay_ff   <= abs_val(req_data.accel_y);
         az_ff   <= abs_val(req_data.accel_z);
         neg_ff  <= req_data.accel_x[SAMPLE_WIDTH-1];
         prod_ff <= '0;
         acc_ff  <= '0;
         srem_ff <= '0;
         root_ff <= '0;
         drem_ff <= {1'b0, ax_in[SAMPLE_WIDTH-1:1]};
         ddvd_ff <= {ax_in[0], {(RATIO_WIDTH-1){1'b0}}};
         quo_ff  <= '0;
      end else if (cmd.sq_step) begin
         prod_ff <= mul_out;
         acc_ff  <= acc_ff + prod_ff;
      end else if (cmd.sqrt_step) begin
         acc_ff  <= {acc_ff[RAD_WIDTH-3:0], 2'b00};
         srem_ff <= srem_in;
         root_ff <= root_in;
      end else if (cmd.div_step) begin
         drem_ff <= drem_in;
         ddvd_ff <= {ddvd_ff[RATIO_WIDTH-2:0], 1'b0};
         quo_ff  <= {quo_ff[RATIO_WIDTH-2:0], qbit};
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: src/vmn_ctrl.sv
// controller: sequences square, root and divide phases and owns both handshakes
// depends on vmn_pkg

module vmn_ctrl
   import vmn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output vmn_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_SQRT   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } vmn_state_type;

   vmn_state_type           state_ff, state_in;
   logic [STEP_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.sq_sel    = SEL_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_SQUARE;
               cnt_in      = '0;
            end
         end
         ST_SQUARE: begin
            cmd.sq_step = 1'b1;
            unique case (cnt_ff[1:0])
               2'd0:    cmd.sq_sel = SEL_X;
               2'd1:    cmd.sq_sel = SEL_Y;
               2'd2:    cmd.sq_sel = SEL_Z;
               default: cmd.sq_sel = SEL_NONE;
            endcase
            if (cnt_ff == STEP_WIDTH'(SQ_STEPS - 1)) begin
               state_in = ST_SQRT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + STEP_WIDTH'(1);
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == STEP_WIDTH'(SQRT_STEPS - 1)) begin
               state_in = ST_DIVIDE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + STEP_WIDTH'(1);
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == STEP_WIDTH'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + STEP_WIDTH'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SQUARE))
      else $error("accepted item did not start squaring");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_sqrt_count_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT && $past(state_ff == ST_SQUARE)) |-> (cnt_ff == '0))
      else $error("root step count not cleared");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.load_out)
      else $error("stalled result overwritten");
`endif

endmodule

FILE: src/vector_magnitude_and_norm.sv
// top level of the vector magnitude and norm block
// depends on vmn_pkg, vmn_ctrl, vmn_datapath

// Takes one signed 16-bit three-axis sample per request transfer and returns one
// response transfer holding floor(sqrt(x*x + y*y + z*z)) and x / length in Q1.15,
// truncated toward zero, +1 saturated to 32767, 0 for a zero vector. Nothing is
// kept between samples. An accepted sample passes through the shared squarer,
// the bit-serial square root (two radicand bits per cycle) and the restoring
// divider (one quotient bit per cycle), then loads the output register, which
// raises the response valid; a new request is taken only after that load. The
// output register lets the next sample be accepted and worked on while a response
// still waits on rsp_stall; that sample then holds in the finish state until the
// register frees.

module vector_magnitude_and_norm
   import vmn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  vmn_req_type req_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output vmn_rsp_type rsp_data
);

   // command bundle from controller to datapath
   vmn_cmd_type cmd;

   // phase sequencing and handshakes
   vmn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // arithmetic and response register
   vmn_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

FILE: tb/vmn_norm_checker.sv
// transfer monitor and predictor for vector_magnitude_and_norm
// depends on vmn_pkg; reports a mismatch count and the number of samples still awaited

module vmn_norm_checker
   import vmn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  vmn_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  vmn_rsp_type rsp_data,
   output int          mismatch_count,
   output int          open_count
);

   localparam longint RATIO_MAX = 32767;
   localparam longint RATIO_ONE = 32768;
   localparam longint LEN_MAX   = 65535;

   vmn_rsp_type awaited_norms[$];

   // floor of the euclidean length, then |x| * 2^15 / length carrying the sign of x
   function automatic vmn_rsp_type norm_of_sample(vmn_req_type s);
      longint      sx, mx, my, mz;
      longint      energy, root, trial, quot;
      vmn_rsp_type r;
      sx = longint'(s.accel_x);
      mx = (sx < 0) ? -sx : sx;
      my = (longint'(s.accel_y) < 0) ? -longint'(s.accel_y) : longint'(s.accel_y);
      mz = (longint'(s.accel_z) < 0) ? -longint'(s.accel_z) : longint'(s.accel_z);
      energy = mx * mx + my * my + mz * mz;
      // root built from the top bit down, keeping each bit whose square still fits
      root = 0;
      for (int b = 17; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= energy)
            root = trial;
      end
      quot = 0;
      if (root != 0) begin
         quot = (mx << 15) / root;
         if (quot > RATIO_ONE)
            quot = RATIO_ONE;
      end
      if (sx < 0)
         r.x_ratio = RATIO_WIDTH'(-quot);
      else
         r.x_ratio = RATIO_WIDTH'((quot > RATIO_MAX) ? RATIO_MAX : quot);
      r.vector_length = ROOT_WIDTH'((root > LEN_MAX) ? LEN_MAX : root);
      return r;
   endfunction

   initial begin
      mismatch_count = 0;
      open_count     = 0;
   end

   always @(posedge clock) begin
      vmn_rsp_type want;
      int          errs;
      errs = 0;
      if (!reset) begin
         // the response side goes first so a same-edge request never matches itself
         if (rsp_valid && !rsp_stall) begin
            if (awaited_norms.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual length %0d ratio %0d",
                        $time, rsp_data.vector_length, rsp_data.x_ratio);
               errs++;
            end else begin
               want = awaited_norms.pop_front();
               if (rsp_data.vector_length !== want.vector_length) begin
                  $display("%0t: vector_length mismatch: expected %0d, actual %0d",
                           $time, want.vector_length, rsp_data.vector_length);
                  errs++;
               end
               if (rsp_data.x_ratio !== want.x_ratio) begin
                  $display("%0t: x_ratio mismatch: expected %0d, actual %0d",
                           $time, want.x_ratio, rsp_data.x_ratio);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_norms.push_back(norm_of_sample(req_data));
      end
      mismatch_count <= mismatch_count + errs;
      open_count     <= awaited_norms.size();
   end

endmodule

FILE: tb/tb.sv
// stimulus and verdict for vector_magnitude_and_norm
// depends on vmn_pkg, vmn_norm_checker and the block itself

module tb;
   import vmn_pkg::*;

   localparam int SAMPLE_COUNT = 1650;
   // the slowest legal item combines a long gap, the busy phases and a long stall
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int TAIL_CYCLES  = 80;

   // corner samples: zero vector, plus and minus one, full scale, tiny and mixed signs
   localparam int CORNER_SET [20][3] = '{
      '{0, 0, 0},
      '{32767, 0, 0},
      '{-32768, 0, 0},
      '{1, 0, 0},
      '{-1, 0, 0},
      '{0, 1, 0},
      '{0, 0, -1},
      '{32767, 32767, 32767},
      '{-32768, -32768, -32768},
      '{0, 32767, -32768},
      '{-32768, 32767, 0},
      '{32767, -32768, -32768},
      '{3, 4, 0},
      '{-3, 4, 12},
      '{1, 1, 1},
      '{-1, -1, -1},
      '{21845, 10922, -21846},
      '{-21846, -10923, 21845},
      '{0, -32768, 0},
      '{16384, 0, 0}
   };

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   vmn_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   vmn_rsp_type rsp_data;

   // while set, neither side idles
   logic        steady    = 1'b0;
   int          mismatch_count;
   int          open_count;
   int          cycle_count = 0;

   vector_magnitude_and_norm i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   vmn_norm_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .open_count     (open_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_idle();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      else if (pick < 88)
         return $urandom_range(1, 3);
      else if (pick < 97)
         return $urandom_range(4, 24);
      else
         return $urandom_range(60, 200);
   endfunction

   // full-scale, unit and zero corners plus an occasional random value
   function automatic logic signed [SAMPLE_WIDTH-1:0] corner_value();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_WIDTH'(-32768);
         1:       return SAMPLE_WIDTH'(-32767);
         2:       return SAMPLE_WIDTH'(-1);
         3:       return SAMPLE_WIDTH'(0);
         4:       return SAMPLE_WIDTH'(1);
         5:       return SAMPLE_WIDTH'(32766);
         6:       return SAMPLE_WIDTH'(32767);
         default: return SAMPLE_WIDTH'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic vmn_req_type random_sample();
      vmn_req_type s;
      int          mode;
      mode = $urandom_range(0, 99);
      s.accel_x = SAMPLE_WIDTH'($urandom_range(0, 65535));
      s.accel_y = SAMPLE_WIDTH'($urandom_range(0, 65535));
      s.accel_z = SAMPLE_WIDTH'($urandom_range(0, 65535));
      if (mode < 15) begin
         // tiny vectors: small roots where truncation matters most
         s.accel_x = SAMPLE_WIDTH'($urandom_range(0, 16) - 8);
         s.accel_y = SAMPLE_WIDTH'($urandom_range(0, 16) - 8);
         s.accel_z = SAMPLE_WIDTH'($urandom_range(0, 16) - 8);
      end else if (mode < 27) begin
         // nearly pure x: ratio near plus or minus one, saturation path
         s.accel_y = SAMPLE_WIDTH'($urandom_range(0, 4) - 2);
         s.accel_z = (mode < 21) ? '0 : SAMPLE_WIDTH'($urandom_range(0, 4) - 2);
      end else if (mode < 42) begin
         s.accel_x = corner_value();
         s.accel_y = corner_value();
         s.accel_z = corner_value();
      end
      return s;
   endfunction

   // one request transfer, after an optional idle gap; valid stays high when gap is zero
   task automatic offer_sample(input vmn_req_type s, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender holds off until every response has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   // response side: random runs of ready and stalled cycles
   initial begin
      int run;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (steady || $urandom_range(0, 1) == 0) begin
            rsp_stall <= 1'b0;
            run = steady ? 1 : 1 + pick_idle();
         end else begin
            rsp_stall <= 1'b1;
            run = 1 + pick_idle();
         end
         repeat (run) @(posedge clock);
      end
   end

   initial begin
      vmn_req_type s;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed corners first
      foreach (CORNER_SET[n]) begin
         s.accel_x = SAMPLE_WIDTH'(CORNER_SET[n][0]);
         s.accel_y = SAMPLE_WIDTH'(CORNER_SET[n][1]);
         s.accel_z = SAMPLE_WIDTH'(CORNER_SET[n][2]);
         offer_sample(s, pick_idle());
      end
      hold_until_drained();

      // random samples, with one stretch of requests offered without idle gaps and a full drain midway
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         if (i == 300)
            steady <= 1'b1;
         if (i == 500)
            steady <= 1'b0;
         if (i == 900)
            hold_until_drained();
         offer_sample(random_sample(), (i >= 300 && i < 500) ? 0 : pick_idle());
      end
      req_valid <= 1'b0;

      // wait for the last responses, then a little longer to catch strays
      do @(posedge clock); while (open_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

FILE: filelist.f
src/vmn_pkg.sv
src/vmn_datapath.sv
src/vmn_ctrl.sv
src/vector_magnitude_and_norm.sv
tb/vmn_norm_checker.sv
tb/tb.sv
